### src/scandg_pkg.sv
// Shared types and constants for the beam-to-grid-cell projector.
// No dependencies; imported by the top level, front end, queue and back end.
`timescale 1ns / 1ps
`default_nettype none
package scandg_pkg;

    localparam int AHEAD_CELLS_DEF   = 256;
    localparam int LATERAL_CELLS_DEF = 256;
    localparam int DILATION_DEF      = 3;

    localparam int COORD_W    = 8;   // holds any coordinate for grids up to 256 cells
    localparam int QUEUE_DEPTH = 4;

    // register indexes of the configuration port
    localparam logic [7:0] REG_START_ANGLE     = 8'd0;
    localparam logic [7:0] REG_ANGLE_STEP      = 8'd1;
    localparam logic [7:0] REG_CELLS_PER_METRE = 8'd2;
    localparam logic [7:0] REG_LATERAL_OFFSET  = 8'd3;

    localparam logic [15:0] START_ANGLE_RST     = 16'd0;
    localparam logic [15:0] ANGLE_STEP_RST      = 16'd0;
    localparam logic [15:0] CELLS_PER_METRE_RST = 16'd2560;
    localparam logic [7:0]  LATERAL_OFFSET_RST  = 8'd128;

    // odd sine polynomial coefficients, Q30
    localparam logic [31:0] SIN_C1 = 32'd1686629713;
    localparam logic [31:0] SIN_C3 = 32'd693598668;
    localparam logic [31:0] SIN_C5 = 32'd85569303;
    localparam logic [31:0] SIN_C7 = 32'd5026995;

    localparam logic [15:0] QUARTER_TURN = 16'd16384;

    // clipped dilation square of one beam
    typedef struct packed {
        logic [COORD_W-1:0] a_lo;
        logic [COORD_W-1:0] a_hi;
        logic [COORD_W-1:0] l_lo;
        logic [COORD_W-1:0] l_hi;
    } t_span;

    typedef struct packed {
        logic  valid;
        logic  full;
    } t_queue_stat;

endpackage
`default_nettype wire

### src/scan_to_dilated_grid_cells.sv
// Beam-to-grid-cell projector: one beam in, the in-bounds cells of its dilation square out.
// A beam's first cell passes through the 9-stage front pipeline, the queue, the walker load and
// the output register. The front end takes one beam per cycle unless a finished beam waits on a
// full queue; the walker emits one cell per cycle while the output is not stalled and pauses to
// load each beam of at most (2*DILATION+1)^2 cells; empty beams never reach the queue.
// Reset (synchronous, active low) empties pipeline and queue and restores register defaults.
`timescale 1ns / 1ps
`default_nettype none
module scan_to_dilated_grid_cells #(
    parameter int AHEAD_CELLS   = scandg_pkg::AHEAD_CELLS_DEF,
    parameter int LATERAL_CELLS = scandg_pkg::LATERAL_CELLS_DEF,
    parameter int DILATION      = scandg_pkg::DILATION_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [31:0] i_s_axis_tdata,   // beam_index[11:0], beam_range[27:12], zero
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [15:0]      o_m_axis_tdata,   // cell_index[15:0]
    output logic             o_m_axis_tlast,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [7:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);
    import scandg_pkg::*;

    logic [15:0] r_start_angle, r_angle_step, r_cells_per_metre;
    logic [7:0]  r_lateral_offset;

    t_queue_stat w_q;
    t_span       w_push_span, w_head_span;
    logic        w_push, w_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_angle     <= START_ANGLE_RST;
            r_angle_step      <= ANGLE_STEP_RST;
            r_cells_per_metre <= CELLS_PER_METRE_RST;
            r_lateral_offset  <= LATERAL_OFFSET_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_START_ANGLE:     r_start_angle     <= i_cfg_data;
                REG_ANGLE_STEP:      r_angle_step      <= i_cfg_data;
                REG_CELLS_PER_METRE: r_cells_per_metre <= i_cfg_data;
                REG_LATERAL_OFFSET:  r_lateral_offset  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    scandg_front #(
        .AHEAD_CELLS(AHEAD_CELLS), .LATERAL_CELLS(LATERAL_CELLS), .DILATION(DILATION)
    ) u_front (
        .i_clk, .i_rst_n,
        .i_valid          (i_s_axis_tvalid),
        .o_ready          (o_s_axis_tready),
        .i_beam_index     (i_s_axis_tdata[11:0]),
        .i_beam_range     (i_s_axis_tdata[27:12]),
        .i_start_angle    (r_start_angle),
        .i_angle_step     (r_angle_step),
        .i_cells_per_metre(r_cells_per_metre),
        .i_lateral_offset (r_lateral_offset),
        .i_q              (w_q),
        .o_push           (w_push),
        .o_span           (w_push_span)
    );

    scandg_queue u_queue (
        .i_clk, .i_rst_n,
        .i_push(w_push), .i_span(w_push_span),
        .i_pop (w_pop),  .o_span(w_head_span),
        .o_stat(w_q)
    );

    scandg_back #(.AHEAD_CELLS(AHEAD_CELLS)) u_back (
        .i_clk, .i_rst_n,
        .i_q         (w_q),
        .i_span      (w_head_span),
        .o_pop       (w_pop),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_cell_index(o_m_axis_tdata),
        .o_last_cell (o_m_axis_tlast)
    );

endmodule
`default_nettype wire

### src/scandg_front.sv
// Front end: beam angle, sine/cosine polynomial, range projection and clipping.
// Uses scandg_pkg; feeds the span queue.
`timescale 1ns / 1ps
`default_nettype none
module scandg_front #(
    parameter int AHEAD_CELLS   = scandg_pkg::AHEAD_CELLS_DEF,
    parameter int LATERAL_CELLS = scandg_pkg::LATERAL_CELLS_DEF,
    parameter int DILATION      = scandg_pkg::DILATION_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire logic [11:0]         i_beam_index,
    input  wire logic [15:0]         i_beam_range,
    input  wire logic [15:0]         i_start_angle,
    input  wire logic [15:0]         i_angle_step,
    input  wire logic [15:0]         i_cells_per_metre,
    input  wire logic [7:0]          i_lateral_offset,
    input  wire scandg_pkg::t_queue_stat i_q,
    output logic                     o_push,
    output scandg_pkg::t_span        o_span
);
    import scandg_pkg::*;

    localparam int NSTG = 9;
    localparam logic signed [18:0] DIL   = 19'(DILATION);
    localparam logic signed [18:0] A_MAX = 19'(AHEAD_CELLS - 1);
    localparam logic signed [18:0] L_MAX = 19'(LATERAL_CELLS - 1);

    logic [NSTG-1:0] r_v;
    logic            w_adv;

    // lane 0 sine, lane 1 cosine
    logic [15:0]        r_ang;
    logic [15:0]        r_rng;
    logic [14:0]        r_r   [1:4][2];
    logic [14:0]        r_x2  [1:3][2];
    logic               r_neg [1:5][2];
    logic [31:0]        r_p   [2:5][2];
    logic [31:0]        r_scale [1:6];
    logic signed [15:0] r_trig [2];
    logic signed [48:0] r_prod [2];
    logic signed [17:0] r_ahead;
    logic signed [18:0] r_lat;

    logic [14:0] n_r  [2];
    logic [14:0] n_x2 [2];
    logic        n_neg [2];
    logic [31:0] n_p2 [2];
    logic [31:0] n_p3 [2];
    logic [31:0] n_p4 [2];
    logic [31:0] n_v  [2];
    logic signed [15:0] n_trig [2];

    logic signed [18:0] w_alo, w_ahi, w_llo, w_lhi;
    logic               w_empty;

    assign w_empty = (w_ahi < 0) || (w_alo > A_MAX) || (w_lhi < 0) || (w_llo > L_MAX);
    assign w_adv   = !r_v[NSTG-1] || w_empty || !i_q.full;
    assign o_ready = w_adv;
    assign o_push  = r_v[NSTG-1] && !w_empty && !i_q.full;

    always_comb begin
        logic [15:0] t;
        logic [29:0] sq;
        logic [46:0] m2, m3, m4, m5;
        logic [16:0] rnd;
        logic [14:0] mag;
        for (int i = 0; i < 2; i++) begin
            t = (i == 0) ? r_ang : r_ang + QUARTER_TURN;
            n_r[i]   = t[14] ? 15'(QUARTER_TURN - {2'b00, t[13:0]}) : {1'b0, t[13:0]};
            n_neg[i] = t[15];
            sq       = n_r[i] * n_r[i];
            n_x2[i]  = sq[28:14];
            m2       = SIN_C7 * r_x2[1][i];
            n_p2[i]  = SIN_C5 - m2[45:14];
            m3       = r_p[2][i] * r_x2[2][i];
            n_p3[i]  = SIN_C3 - m3[45:14];
            m4       = r_p[3][i] * r_x2[3][i];
            n_p4[i]  = SIN_C1 - m4[45:14];
            m5       = r_p[4][i] * r_r[4][i];
            n_v[i]   = m5[45:14];
            rnd      = 17'((r_p[5][i] + 32'd16384) >> 15);
            mag      = (rnd > 17'd32767) ? 15'd32767 : rnd[14:0];
            n_trig[i] = r_neg[5][i] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        end
    end

    // floor of the Q31 product is an arithmetic shift; then clip the square
    always_comb begin
        w_alo = 19'(r_ahead) - DIL;
        w_ahi = 19'(r_ahead) + DIL;
        w_llo = r_lat - DIL;
        w_lhi = r_lat + DIL;
        o_span.a_lo = (w_alo < 0) ? '0 : w_alo[COORD_W-1:0];
        o_span.a_hi = (w_ahi > A_MAX) ? A_MAX[COORD_W-1:0] : w_ahi[COORD_W-1:0];
        o_span.l_lo = (w_llo < 0) ? '0 : w_llo[COORD_W-1:0];
        o_span.l_hi = (w_lhi > L_MAX) ? L_MAX[COORD_W-1:0] : w_lhi[COORD_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_adv) begin
            r_v <= {r_v[NSTG-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_ang <= 16'(i_start_angle + i_beam_index * i_angle_step);
            r_rng <= i_beam_range;
            r_scale[1] <= r_rng * i_cells_per_metre;
            for (int s = 2; s <= 6; s++) r_scale[s] <= r_scale[s-1];
            for (int i = 0; i < 2; i++) begin
                r_r[1][i]   <= n_r[i];
                r_x2[1][i]  <= n_x2[i];
                r_neg[1][i] <= n_neg[i];
                for (int s = 2; s <= 4; s++) r_r[s][i] <= r_r[s-1][i];
                for (int s = 2; s <= 3; s++) r_x2[s][i] <= r_x2[s-1][i];
                for (int s = 2; s <= 5; s++) r_neg[s][i] <= r_neg[s-1][i];
                r_p[2][i]  <= n_p2[i];
                r_p[3][i]  <= n_p3[i];
                r_p[4][i]  <= n_p4[i];
                r_p[5][i]  <= n_v[i];
                r_trig[i]  <= n_trig[i];
                r_prod[i]  <= $signed({1'b0, r_scale[6]}) * r_trig[i];
            end
            r_ahead <= r_prod[1][48:31];
            r_lat   <= 19'($signed(r_prod[0][48:31])) + $signed({11'b0, i_lateral_offset});
        end
    end

endmodule
`default_nettype wire

### src/scandg_queue.sv
// Short queue of clipped spans between the front end and the cell walker.
// Uses scandg_pkg.
`timescale 1ns / 1ps
`default_nettype none
module scandg_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire scandg_pkg::t_span i_span,
    input  wire logic              i_pop,
    output scandg_pkg::t_span      o_span,
    output scandg_pkg::t_queue_stat o_stat
);
    import scandg_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_span          r_mem [QUEUE_DEPTH];
    logic [PW-1:0]  r_wp, r_rp;
    logic [CW-1:0]  r_cnt;

    assign o_stat.valid = (r_cnt != '0);
    assign o_stat.full  = (r_cnt == CW'(QUEUE_DEPTH));
    assign o_span       = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_span;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + CW'(i_push) - CW'(i_pop);
        end
    end

endmodule
`default_nettype wire

### src/scandg_back.sv
// Back end: walks each clipped span, ahead outer and lateral inner, one cell per cycle while not stalled.
// Uses scandg_pkg; drives the registered result channel.
`timescale 1ns / 1ps
`default_nettype none
module scandg_back #(
    parameter int AHEAD_CELLS = scandg_pkg::AHEAD_CELLS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire scandg_pkg::t_queue_stat i_q,
    input  wire scandg_pkg::t_span      i_span,
    output logic                        o_pop,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output logic [15:0]                 o_cell_index,
    output logic                        o_last_cell
);
    import scandg_pkg::*;

    logic               r_busy;
    t_span              r_sp;
    logic [COORD_W-1:0] r_a, r_l;
    logic               r_ov;
    logic [15:0]        r_idx;
    logic               r_last;
    logic               w_slot, w_end_row, w_end;

    assign w_slot    = !r_ov || i_ready;
    assign w_end_row = (r_l == r_sp.l_hi);
    assign w_end     = w_end_row && (r_a == r_sp.a_hi);
    assign o_pop     = !r_busy && i_q.valid;

    assign o_valid      = r_ov;
    assign o_cell_index = r_idx;
    assign o_last_cell  = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
            end else if (r_busy && w_slot && w_end) begin
                r_busy <= 1'b0;
            end
            if (w_slot) r_ov <= r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_sp <= i_span;
            r_a  <= i_span.a_lo;
            r_l  <= i_span.l_lo;
        end else if (r_busy && w_slot) begin
            if (w_end_row) begin
                r_l <= r_sp.l_lo;
                r_a <= r_a + 1'b1;
            end else begin
                r_l <= r_l + 1'b1;
            end
        end
        if (r_busy && w_slot) begin
            r_idx  <= 16'(32'(r_a) * AHEAD_CELLS + 32'(r_l));
            r_last <= w_end;
        end
    end

endmodule
`default_nettype wire

### src/scandg_checker.sv
// Port-level checks for the projector, bound to the top level.
// Depends only on the top-level ports.
`timescale 1ns / 1ps
`default_nettype none
module scandg_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_m_axis_tvalid,
    input wire logic        i_m_axis_tready,
    input wire logic [15:0] o_m_axis_tdata,
    input wire logic        o_m_axis_tlast
);
    // results never appear straight out of reset
    a_rst_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("stalled result changed");

    // cells of one beam follow without gaps
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && i_m_axis_tready && !o_m_axis_tlast |=> o_m_axis_tvalid)
        else $error("gap inside a beam's cells");
endmodule

bind scan_to_dilated_grid_cells scandg_checker u_scandg_checker (
    .i_clk, .i_rst_n, .o_m_axis_tvalid, .i_m_axis_tready, .o_m_axis_tdata, .o_m_axis_tlast
);
`default_nettype wire
